// ----- rtl/vlp_pkg.sv -----
// shared types, constants and helpers for the vertex light and project block
// no dependencies
package vlp_pkg;

	localparam int WorldW   = 24;
	localparam int NormW    = 16;
	localparam int ColW     = 24;
	localparam int ScrW     = 16;
	localparam int GainW    = 10;
	localparam int CfgW     = 48;
	localparam int CfgIdxW  = 3;
	localparam int InDataW  = 144;
	localparam int OutDataW = 64;
	localparam int DivQW    = 48;
	localparam int DivDW    = 24;
	localparam int DotW     = 34;
	localparam int QueueDepthDefault = 4;
	localparam logic signed [WorldW-1:0] ZNearLimit = -24'sd384000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AMBIENT   = 3'd0,
		REG_DIRECT    = 3'd1,
		REG_LIGHT_DIR = 3'd2,
		REG_ORIGIN_X  = 3'd3,
		REG_ORIGIN_Y  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [WorldW-1:0] wx;
		logic signed [WorldW-1:0] wy;
		logic signed [WorldW-1:0] wz;
		logic signed [NormW-1:0]  nx;
		logic signed [NormW-1:0]  ny;
		logic signed [NormW-1:0]  nz;
		logic [ColW-1:0]          col;
		logic                     last;
		logic                     keep;
	} vtx_t;

	typedef struct packed {
		logic                   visible;
		logic [ColW-1:0]        col;
		logic signed [ScrW-1:0] sx;
		logic signed [ScrW-1:0] sy;
		logic                   last;
	} res_t;

	function automatic logic signed [ScrW-1:0] sat16(input logic signed [DivQW:0] v);
		logic signed [ScrW-1:0] r;
		if (v > 49'sd32767) r = 16'sh7fff;
		else if (v < -49'sd32768) r = -16'sh8000;
		else r = v[ScrW-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/vlp_front.sv -----
// front end: unpacks incoming vertices, classifies depth range, feeds the queue
// depends on vlp_pkg
module vlp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [vlp_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                         s_axis_tlast,
	output logic                         q_valid,
	input  logic                         q_ready,
	output vlp_pkg::vtx_t                q_data
);
	import vlp_pkg::*;

	vtx_t v;
	logic valid_q;
	vtx_t data_q;

	always_comb begin
		v.wx   = s_axis_tdata[23:0];
		v.wy   = s_axis_tdata[47:24];
		v.wz   = s_axis_tdata[71:48];
		v.nx   = s_axis_tdata[87:72];
		v.ny   = s_axis_tdata[103:88];
		v.nz   = s_axis_tdata[119:104];
		v.col  = s_axis_tdata[143:120];
		v.last = s_axis_tlast;
		v.keep = (v.wz < 0) && (v.wz >= ZNearLimit);
	end

	assign s_axis_tready = !valid_q || q_ready;
	assign q_valid = valid_q;
	assign q_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_q <= v;
		end
	end
endmodule

// ----- rtl/vlp_queue.sv -----
// small fifo between front and back halves
// depends on vlp_pkg
module vlp_queue #(
	parameter int Depth = vlp_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vlp_pkg::vtx_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output vlp_pkg::vtx_t out_data
);
	import vlp_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	vtx_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign in_ready  = cnt_q != (AW+1)'(Depth);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

// ----- rtl/vlp_div.sv -----
// pipelined signed divider, one quotient bit per stage, truncating toward zero
// depends on vlp_pkg
module vlp_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [vlp_pkg::DivQW-1:0]   num,
	input  logic signed [vlp_pkg::DivDW-1:0]   den,
	output logic signed [vlp_pkg::DivQW:0]     quo
);
	import vlp_pkg::*;
	localparam int N = DivQW;

	logic [N-1:0]   q_s   [N+1];
	logic [DivDW:0] r_s   [N+1];
	logic [DivDW-1:0] d_s [N+1];
	logic           neg_s [N+1];

	always_comb begin
		q_s[0]   = num[N-1] ? N'(-num) : N'(num);
		r_s[0]   = '0;
		d_s[0]   = den[DivDW-1] ? DivDW'(-den) : DivDW'(den);
		neg_s[0] = num[N-1] ^ den[DivDW-1];
	end

	// each stage shifts in one dividend bit and makes one quotient bit
	for (genvar i = 0; i < N; i++) begin : g_st
		logic [DivDW+1:0] t;
		logic [DivDW+1:0] dif;
		always_comb begin
			t   = {r_s[i], q_s[i][N-1]};
			dif = t - {2'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!dif[DivDW+1]) begin
					r_s[i+1] <= dif[DivDW:0];
					q_s[i+1] <= {q_s[i][N-2:0], 1'b1};
				end else begin
					r_s[i+1] <= t[DivDW:0];
					q_s[i+1] <= {q_s[i][N-2:0], 1'b0};
				end
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign quo = neg_s[N] ? -$signed({1'b0, q_s[N]}) : $signed({1'b0, q_s[N]});
endmodule

// ----- rtl/vlp_back.sv -----
// back end: lighting and projection pipeline with output register
// depends on vlp_pkg, vlp_div
module vlp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  vlp_pkg::vtx_t                     q_data,
	input  logic [3*vlp_pkg::GainW-1:0]       amb,
	input  logic [3*vlp_pkg::GainW-1:0]       dir,
	input  logic [3*vlp_pkg::NormW-1:0]       ldir,
	input  logic signed [vlp_pkg::ScrW-1:0]   ox,
	input  logic signed [vlp_pkg::ScrW-1:0]   oy,
	output logic                              m_valid,
	input  logic                              m_ready,
	output vlp_pkg::res_t                     m_data
);
	import vlp_pkg::*;
	localparam int L = DivQW + 3;

	logic adv;
	logic [L-1:0] v_s;
	vtx_t p1_s;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [DivQW-1:0] numx_s1, numy_s1;
	logic signed [DotW-1:0] dot_s2;
	vtx_t p2_s;
	logic signed [DivQW-1:0] numx_s2, numy_s2;
	logic [7:0] ch_s [DivQW+1];
	logic [7:0] chg_s [DivQW+1];
	logic [7:0] chb_s [DivQW+1];
	logic [DivQW:0] keep_s, last_s;
	logic signed [DivQW:0] qx, qy;
	logic [7:0] lit [3];
	logic signed [44:0] gd_s3 [3];
	logic [7:0] c_s3 [3];
	logic [9:0] amb_s3 [3];
	vtx_t p3_s;
	logic signed [DivQW-1:0] numx_s3, numy_s3;
	logic out_v_q;
	res_t out_q;

	// pipeline advances whenever the output register can take a result or the last stage holds no vertex
	assign adv = !out_v_q || m_ready || !v_s[L-1];
	assign q_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) v_s <= {v_s[L-2:0], q_valid};
			if (m_ready || !out_v_q) out_v_q <= adv && v_s[L-1];
		end
	end

	// stage 1: products for dot and projection numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s  <= q_data;
			px_s1 <= q_data.nx * $signed(ldir[47:32]);
			py_s1 <= q_data.ny * $signed(ldir[31:16]);
			pz_s1 <= q_data.nz * $signed(ldir[15:0]);
			numx_s1 <= DivQW'(ox) * DivQW'(q_data.wz) + DivQW'(q_data.wx) * 48'sd1000;
			numy_s1 <= DivQW'(oy) * DivQW'(q_data.wz) - DivQW'(q_data.wy) * 48'sd1000;
		end
	end

	// stage 2: dot sum
	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s <= p1_s;
			dot_s2 <= DotW'(px_s1) + DotW'(py_s1) + DotW'(pz_s1);
			numx_s2 <= numx_s1;
			numy_s2 <= numy_s1;
		end
	end

	// stage 3: gain times dot, ambient term
	for (genvar k = 0; k < 3; k++) begin : g_ch
		logic [7:0] c;
		logic [17:0] ap;
		assign c  = p2_s.col[8*k +: 8];
		assign ap = amb[GainW*k +: GainW] * c;
		always_ff @(posedge clk) begin
			if (adv) begin
				gd_s3[k]  <= $signed({1'b0, dir[GainW*k +: GainW]}) * dot_s2;
				c_s3[k]   <= c;
				amb_s3[k] <= ap[17:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s <= p2_s;
			numx_s3 <= p2_s.keep ? numx_s2 : '0;
			numy_s3 <= p2_s.keep ? numy_s2 : '0;
		end
	end

	// stage 4: times channel, add ambient, clamp
	for (genvar k = 0; k < 3; k++) begin : g_lit
		logic signed [53:0] prod;
		logic signed [54:0] s;
		logic [17:0] ip;
		logic [9:0] ab;
		assign ab   = amb_s3[k];
		assign prod = gd_s3[k] * $signed({1'b0, c_s3[k]});
		assign s    = {{9{1'b0}}, ab, 36'd0} + 55'(prod);
		assign ip   = s[53:36];
		assign lit[k] = (s <= 0) ? 8'd0 : (s[54:36] > 19'sd255 ? 8'd255 : ip[7:0]);
	end

	assign ch_s[0]  = lit[0];
	assign chg_s[0] = lit[1];
	assign chb_s[0] = lit[2];
	assign keep_s[0] = p3_s.keep;
	assign last_s[0] = p3_s.last;

	for (genvar i = 0; i < DivQW; i++) begin : g_dl
		always_ff @(posedge clk) begin
			if (adv) begin
				ch_s[i+1]  <= ch_s[i];
				chg_s[i+1] <= chg_s[i];
				chb_s[i+1] <= chb_s[i];
				keep_s[i+1] <= keep_s[i];
				last_s[i+1] <= last_s[i];
			end
		end
	end

	vlp_div u_divx (.clk(clk), .en(adv), .num(numx_s3),
		.den(p3_s.keep ? p3_s.wz : -24'sd1), .quo(qx));
	vlp_div u_divy (.clk(clk), .en(adv), .num(numy_s3),
		.den(p3_s.keep ? p3_s.wz : -24'sd1), .quo(qy));

	// divider output aligns with the end of the delay line
	always_ff @(posedge clk) begin
		if (adv && (m_ready || !out_v_q)) begin
			out_q.visible <= keep_s[DivQW];
			out_q.col <= keep_s[DivQW] ? {chb_s[DivQW], chg_s[DivQW], ch_s[DivQW]} : '0;
			out_q.sx  <= keep_s[DivQW] ? sat16(qx) : '0;
			out_q.sy  <= keep_s[DivQW] ? sat16(qy) : '0;
			out_q.last <= last_s[DivQW];
		end
	end

	assign m_valid = out_v_q;
	assign m_data  = out_q;
endmodule

// ----- rtl/vertex_light_and_project_core.sv -----
// top level of the vertex light and project block
// depends on vlp_pkg, vlp_front, vlp_queue, vlp_back, vlp_div
//
// input stream s_axis carries one vertex per transaction, tlast marks the
// last vertex of an object; m_axis returns one result per vertex in order.
// configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata); the user
// must write it only while the block is idle, as the block does not enforce
// this; unknown indexes are ignored. throughput is one vertex per cycle when
// nothing stalls. the result transaction passes through one front register,
// the queue, three back stages ahead of the 48-stage restoring dividers for
// the projection, the dividers and the output register. the back pipeline
// freezes when the output register holds an untaken result and the last
// stage holds a vertex; the queue then fills before s_axis_tready drops.
// reset clears all valid flags and zeroes the configuration registers.
module vertex_light_and_project_core #(
	parameter int QueueDepth = vlp_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// world_x, world_y, world_z, normal_x, normal_y, normal_z, base_colour
	input  logic [vlp_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// visible, lit_colour, screen_x, screen_y
	output logic [vlp_pkg::OutDataW-1:0] m_axis_tdata,
	output logic                         m_axis_tlast,
	input  logic                         cfg_we,
	input  logic [vlp_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [vlp_pkg::CfgW-1:0]     cfg_wdata
);
	import vlp_pkg::*;

	logic [3*GainW-1:0] amb_q, dir_q;
	logic [3*NormW-1:0] ldir_q;
	logic signed [ScrW-1:0] ox_q, oy_q;
	logic f_valid, f_ready, b_valid, b_ready;
	vtx_t f_data, b_data;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q <= '0;
			dir_q <= '0;
			ldir_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_AMBIENT:   amb_q  <= cfg_wdata[3*GainW-1:0];
				REG_DIRECT:    dir_q  <= cfg_wdata[3*GainW-1:0];
				REG_LIGHT_DIR: ldir_q <= cfg_wdata[3*NormW-1:0];
				REG_ORIGIN_X:  ox_q   <= cfg_wdata[ScrW-1:0];
				REG_ORIGIN_Y:  oy_q   <= cfg_wdata[ScrW-1:0];
				default: ;
			endcase
		end
	end

	vlp_front u_front (.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast), .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data));

	vlp_queue #(.Depth(QueueDepth)) u_queue (.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data));

	vlp_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(b_valid), .q_ready(b_ready),
		.q_data(b_data), .amb(amb_q), .dir(dir_q), .ldir(ldir_q), .ox(ox_q), .oy(oy_q),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(res));

	assign m_axis_tdata = {7'd0, res.sy, res.sx, res.col, res.visible};
	assign m_axis_tlast = res.last;
endmodule

// ----- tb/sv/vertex_light_and_project_core_tb.sv -----
// self-checking testbench for vertex_light_and_project_core
// depends on vlp_pkg and the core rtl; predicts lit colour and screen position per vertex
module vertex_light_and_project_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vlp_pkg::*;

	localparam int SettleCycles = 70;
	localparam logic [CfgIdxW-1:0] REG_IDX_MAX = '1;

	typedef struct {
		logic signed [WorldW-1:0] wx, wy, wz;
		logic signed [NormW-1:0]  nx, ny, nz;
		logic [ColW-1:0]          col;
		logic                     last;
	} vertex_t;

	typedef struct {
		logic                   visible;
		logic [ColW-1:0]        col;
		logic signed [ScrW-1:0] sx, sy;
		logic                   last;
	} shaded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgW-1:0] cfg_wdata = '0;

	// shadow of the configuration registers
	logic [29:0] amb_gains, dir_gains;
	logic [47:0] light_dir;
	logic signed [15:0] org_x, org_y;

	vertex_t vertex_q[$];
	vertex_t in_flight;
	shaded_t shaded_q[$];
	int errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit no_gaps = 0;
	bit in_taken = 0;

	vertex_light_and_project_core dut (.*);

	always #10 clk = ~clk;

	function automatic logic [7:0] shade_channel(longint c, longint a, longint g, longint dot);
		longint amb, s, r;
		amb = (a * c) >>> 8;
		s = amb * (64'sd1 <<< 36) + g * dot * c;
		if (s <= 0) return 8'd0;
		r = s >>> 36;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return -16'sh8000;
		return v[15:0];
	endfunction

	function automatic shaded_t light_and_project(vertex_t v);
		shaded_t o;
		longint wz, dot, lx, ly, lz;
		o = '{default: 0};
		o.last = v.last;
		wz = v.wz;
		if (wz >= 0 || wz < -384000) return o;
		lx = $signed(light_dir[47:32]);
		ly = $signed(light_dir[31:16]);
		lz = $signed(light_dir[15:0]);
		dot = longint'(v.nx) * lx + longint'(v.ny) * ly + longint'(v.nz) * lz;
		for (int k = 0; k < 3; k++)
			o.col[k*8 +: 8] = shade_channel(v.col[k*8 +: 8], amb_gains[k*10 +: 10],
				dir_gains[k*10 +: 10], dot);
		o.sx = clamp16((longint'(org_x) * wz + longint'(v.wx) * 1000) / wz);
		o.sy = clamp16((longint'(org_y) * wz - longint'(v.wy) * 1000) / wz);
		o.visible = 1'b1;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: new vertex once the previous transaction went through
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (vertex_q.size() > 0) begin
				in_flight = vertex_q.pop_front();
				s_axis_tdata <= {in_flight.col, in_flight.nz, in_flight.ny,
					in_flight.nx, in_flight.wz, in_flight.wy, in_flight.wx};
				s_axis_tlast <= in_flight.last;
				s_axis_tvalid <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	// monitor: predict on input transaction, check on output transaction
	always @(posedge clk) begin
		shaded_t exp_r;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			shaded_q.push_back(light_and_project(in_flight));
		if (m_axis_tvalid && m_axis_tready) begin
			if (shaded_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				exp_r = shaded_q.pop_front();
				if (m_axis_tdata[0] !== exp_r.visible) begin
					$error("visible: expected %0d, got %0d", exp_r.visible, m_axis_tdata[0]);
					errors++;
				end
				if (m_axis_tdata[24:1] !== exp_r.col) begin
					$error("lit_colour: expected %h, got %h", exp_r.col, m_axis_tdata[24:1]);
					errors++;
				end
				if (m_axis_tdata[40:25] !== exp_r.sx) begin
					$error("screen_x: expected %0d, got %0d", exp_r.sx,
						$signed(m_axis_tdata[40:25]));
					errors++;
				end
				if (m_axis_tdata[56:41] !== exp_r.sy) begin
					$error("screen_y: expected %0d, got %0d", exp_r.sy,
						$signed(m_axis_tdata[56:41]));
					errors++;
				end
				if (m_axis_tlast !== exp_r.last) begin
					$error("last_out: expected %0d, got %0d", exp_r.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_AMBIENT:   amb_gains = val[29:0];
			REG_DIRECT:    dir_gains = val[29:0];
			REG_LIGHT_DIR: light_dir = val[47:0];
			REG_ORIGIN_X:  org_x = val[15:0];
			REG_ORIGIN_Y:  org_y = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [29:0] a, logic [29:0] d, logic [47:0] l,
			logic [15:0] ox, logic [15:0] oy);
		write_reg(REG_AMBIENT, (CfgW'({$urandom, $urandom}) & ~48'h3FFFFFFF) | {18'd0, a});
		write_reg(REG_DIRECT, {18'd0, d});
		write_reg(REG_LIGHT_DIR, l);
		write_reg(REG_ORIGIN_X, {32'hABCD_0123, ox});
		write_reg(REG_ORIGIN_Y, {32'd0, oy});
	endtask

	task automatic drain();
		wait (vertex_q.size() == 0 && !s_axis_tvalid && shaded_q.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic vertex_t rand_vertex();
		vertex_t v;
		int r;
		v.wx = WorldW'($urandom); v.wy = WorldW'($urandom); v.wz = WorldW'($urandom);
		v.nx = NormW'($urandom); v.ny = NormW'($urandom); v.nz = NormW'($urandom);
		v.col = ColW'($urandom); v.last = 1'($urandom);
		r = $urandom_range(0, 99);
		// most vertices in the visible depth range, some close to zero to saturate
		if (r < 55) v.wz = WorldW'(-$signed($urandom_range(1, 384000)));
		else if (r < 75) v.wz = WorldW'(-$signed($urandom_range(1, 300)));
		else if (r < 80) v.wz = WorldW'(-$signed($urandom_range(383990, 384010)));
		if ($urandom_range(0, 3) == 0) begin
			v.wx = $signed(v.wx) >>> $urandom_range(0, 20);
			v.wy = $signed(v.wy) >>> $urandom_range(0, 20);
		end
		return v;
	endfunction

	function automatic vertex_t mk(int wx, int wy, int wz, int nx, int ny, int nz,
			int col, bit last);
		vertex_t v;
		v.wx = WorldW'(wx); v.wy = WorldW'(wy); v.wz = WorldW'(wz);
		v.nx = NormW'(nx); v.ny = NormW'(ny); v.nz = NormW'(nz);
		v.col = ColW'(col); v.last = last;
		return v;
	endfunction

	initial begin
		amb_gains = '0; dir_gains = '0; light_dir = '0; org_x = '0; org_y = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: only culling and projection matter
		for (int i = 0; i < 20; i++) vertex_q.push_back(rand_vertex());
		drain();

		write_all(30'h3FFFFFFF, 30'h3FFFFFFF, {16'h7fff, 16'h7fff, 16'h7fff},
			16'h7fff, 16'h8000);
		vertex_q.push_back(mk(0, 0, 0, 0, 0, 0, 'hFFFFFF, 1));
		vertex_q.push_back(mk(0, 0, -1, 16'h7fff, 16'h7fff, 16'h7fff, 'hFFFFFF, 0));
		vertex_q.push_back(mk(8388607, -8388608, -1, 0, 0, 0, 'h00FF00, 1));
		vertex_q.push_back(mk(-8388608, 8388607, -1, -32768, -32768, -32768, 'hFF0000, 0));
		vertex_q.push_back(mk(100, -100, -384000, 16384, 0, 0, 'h0000FF, 1));
		vertex_q.push_back(mk(100, -100, -384001, 16384, 0, 0, 'h0000FF, 0));
		vertex_q.push_back(mk(5, 5, 8388607, 0, 0, 0, 'h123456, 1));
		vertex_q.push_back(mk(5, 5, -8388608, 0, 0, 0, 'h123456, 0));
		vertex_q.push_back(mk(8388607, 8388607, -384000, -32768, 32767, 0, 0, 1));
		drain();

		// light opposite most of the normals: negative sums must clamp to zero
		write_all(30'h0, 30'h3FFFFFFF, {16'h8000, 16'h8000, 16'h8000}, 16'h8000, 16'h7fff);
		write_reg(REG_IDX_MAX, '1);
		vertex_q.push_back(mk(256, 256, -256, 16'h7fff, 16'h7fff, 16'h7fff, 'hFFFFFF, 0));
		vertex_q.push_back(mk(-256, -256, -256, -32768, -32768, -32768, 'hFFFFFF, 1));
		vertex_q.push_back(mk(0, 0, -256, 16384, -16384, 0, 'h808080, 0));
		vertex_q.push_back(mk(7, -3, -2, 100, 200, 300, 'hFF00FF, 1));
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			no_gaps = (ph % 4 == 3);
			write_all(30'($urandom), 30'($urandom), CfgW'({$urandom, $urandom}),
				16'($urandom), 16'($urandom));
			if (ph % 3 == 0)
				write_reg(CfgIdxW'($urandom_range(REG_ORIGIN_Y + 1, REG_IDX_MAX)),
					CfgW'({$urandom, $urandom}));
			for (int i = 0; i < 100; i++) vertex_q.push_back(rand_vertex());
			drain();
		end

		if (errors == 0 && shaded_q.size() == 0) begin
			$display("vertex_light_and_project_core_tb: done, clean");
		end else begin
			$display("vertex_light_and_project_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("vertex_light_and_project_core_tb: done, errors");
		$finish;
	end
endmodule
